// File: rtl/core/wfba_pkg.sv
// ----------------------------------------------------------------------------
// wfba_pkg
// Shared types and codes for the worst-fit block allocator.
// ----------------------------------------------------------------------------
package wfba_pkg;

	// request kinds
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_ALLOC = 1'b1;

	typedef enum logic [1:0] {
		ST_LOADED        = 2'd0,
		ST_ALLOCATED     = 2'd1,
		ST_NOT_ALLOCATED = 2'd2,
		ST_FULL          = 2'd3
	} status_t;

	// control half of the scan token passed from cell to cell
	typedef struct packed {
		logic valid;
		logic found;
	} scan_ctl_t;

endpackage

// File: rtl/core/wfba_cell.sv
// ----------------------------------------------------------------------------
// wfba_cell
// One partition slot: holds free and used amounts and folds its entry into
// the scan token that walks down the row, one cell per cycle.
// ----------------------------------------------------------------------------
module wfba_cell
	import wfba_pkg::*;
#(
	parameter int SIZE_BITS = 16,
	parameter int IDX_W     = 4,
	parameter int CELL_IDX  = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 loaded,
	input  logic [SIZE_BITS-1:0] scan_size,
	input  logic                 wr_ld,
	input  logic                 wr_wb,
	input  logic [IDX_W-1:0]     wr_idx,
	input  logic [SIZE_BITS-1:0] wr_size,
	input  scan_ctl_t            in_ctl,
	input  logic [IDX_W-1:0]     in_idx,
	input  logic [SIZE_BITS-1:0] in_free,
	input  logic [SIZE_BITS-1:0] in_used,
	output scan_ctl_t            out_ctl,
	output logic [IDX_W-1:0]     out_idx,
	output logic [SIZE_BITS-1:0] out_free,
	output logic [SIZE_BITS-1:0] out_used
);

	logic [SIZE_BITS-1:0] free_q;
	logic [SIZE_BITS-1:0] used_q;
	scan_ctl_t            ctl_q;
	logic [IDX_W-1:0]     idx_q;
	logic [SIZE_BITS-1:0] bfree_q;
	logic [SIZE_BITS-1:0] bused_q;
	logic                 hit;
	logic                 take;

	assign hit  = (wr_idx == IDX_W'(CELL_IDX));
	// strictly larger keeps ties on the lower index
	assign take = loaded && (free_q >= scan_size) && (!in_ctl.found || free_q > in_free);

	always_ff @(posedge clk) begin
		if (wr_ld && hit) begin
			free_q <= wr_size;
			used_q <= '0;
		end else if (wr_wb && hit) begin
			free_q <= free_q - wr_size;
			used_q <= used_q + wr_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q.valid <= in_ctl.valid;
			ctl_q.found <= in_ctl.found || take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			idx_q   <= IDX_W'(CELL_IDX);
			bfree_q <= free_q;
			bused_q <= used_q;
		end else begin
			idx_q   <= in_idx;
			bfree_q <= in_free;
			bused_q <= in_used;
		end
	end

	assign out_ctl  = ctl_q;
	assign out_idx  = idx_q;
	assign out_free = bfree_q;
	assign out_used = bused_q;

endmodule

// File: rtl/core/worst_fit_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// worst_fit_block_allocator_unit
// Partition table with worst-fit allocation over a row of slot cells.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. Done pulses the cycle
// after a load is accepted and busy never rises, so loads can follow back to
// back. An allocate sends a scan token down the row of MAX_BLOCKS cells, one
// cell per cycle, then writes the chosen slot back if one was found and
// pulses done; it holds busy high until done pulses, so no new word is taken
// while an allocate runs. The receiver cannot stall: done lasts one cycle and
// the result must be taken then.
// ----------------------------------------------------------------------------
module worst_fit_block_allocator_unit
	import wfba_pkg::*;
#(
	parameter int MAX_BLOCKS = 16,
	parameter int SIZE_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [15:0] size_value,
	output logic        done,
	output logic [1:0]  status,
	output logic [3:0]  block_index,
	output logic [15:0] used_after,
	output logic [15:0] free_after
);

	localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

	logic                 busy_q;
	logic                 launch_q;
	logic                 done_q;
	logic [CNT_W-1:0]     count_q;
	logic [SIZE_BITS-1:0] size_q;
	status_t              status_q;
	logic [IDX_W-1:0]     ridx_q;
	logic [SIZE_BITS-1:0] rused_q;
	logic [SIZE_BITS-1:0] rfree_q;

	logic                    accept;
	logic                    do_load;
	logic                    full;
	logic [SIZE_BITS+15:0]   size_ext;
	logic [SIZE_BITS-1:0]    in_size;
	logic                    wr_ld;
	logic                    wr_wb;
	logic [IDX_W-1:0]        wr_idx;
	logic [SIZE_BITS-1:0]    wr_size;
	logic [MAX_BLOCKS-1:0]   loaded;
	logic [IDX_W+3:0]        idx_ext;
	logic [SIZE_BITS+15:0]   used_ext;
	logic [SIZE_BITS+15:0]   free_ext;

	scan_ctl_t            ctl_c  [MAX_BLOCKS+1];
	logic [IDX_W-1:0]     idx_c  [MAX_BLOCKS+1];
	logic [SIZE_BITS-1:0] free_c [MAX_BLOCKS+1];
	logic [SIZE_BITS-1:0] used_c [MAX_BLOCKS+1];

	assign accept   = start && !busy_q;
	assign full     = (count_q == CNT_W'(MAX_BLOCKS));
	assign do_load  = accept && (req_type == REQ_LOAD) && !full;
	// drop input bits above SIZE_BITS, zero-extend below
	assign size_ext = {{SIZE_BITS{1'b0}}, size_value};
	assign in_size  = size_ext[SIZE_BITS-1:0];

	assign wr_ld   = do_load;
	assign wr_wb   = busy_q && ctl_c[MAX_BLOCKS].valid && ctl_c[MAX_BLOCKS].found;
	assign wr_idx  = wr_ld ? count_q[IDX_W-1:0] : idx_c[MAX_BLOCKS];
	assign wr_size = wr_ld ? in_size : size_q;

	assign ctl_c[0].valid = launch_q;
	assign ctl_c[0].found = 1'b0;
	assign idx_c[0]       = '0;
	assign free_c[0]      = '0;
	assign used_c[0]      = '0;

	for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
		assign loaded[i] = (CNT_W'(i) < count_q);

		wfba_cell #(
			.SIZE_BITS(SIZE_BITS),
			.IDX_W    (IDX_W),
			.CELL_IDX (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.loaded   (loaded[i]),
			.scan_size(size_q),
			.wr_ld    (wr_ld),
			.wr_wb    (wr_wb),
			.wr_idx   (wr_idx),
			.wr_size  (wr_size),
			.in_ctl   (ctl_c[i]),
			.in_idx   (idx_c[i]),
			.in_free  (free_c[i]),
			.in_used  (used_c[i]),
			.out_ctl  (ctl_c[i+1]),
			.out_idx  (idx_c[i+1]),
			.out_free (free_c[i+1]),
			.out_used (used_c[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			launch_q <= 1'b0;
			done_q   <= 1'b0;
			count_q  <= '0;
		end else begin
			launch_q <= 1'b0;
			done_q   <= 1'b0;
			if (accept) begin
				done_q <= (req_type == REQ_LOAD);
				if (req_type == REQ_ALLOC) begin
					busy_q   <= 1'b1;
					launch_q <= 1'b1;
				end
				if (do_load) begin
					count_q <= count_q + 1'b1;
				end
			end else if (busy_q && ctl_c[MAX_BLOCKS].valid) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			size_q <= in_size;
			if (req_type == REQ_LOAD) begin
				if (full) begin
					status_q <= ST_FULL;
					ridx_q   <= '0;
					rused_q  <= '0;
					rfree_q  <= '0;
				end else begin
					status_q <= ST_LOADED;
					ridx_q   <= count_q[IDX_W-1:0];
					rused_q  <= '0;
					rfree_q  <= in_size;
				end
			end
		end else if (busy_q && ctl_c[MAX_BLOCKS].valid) begin
			if (ctl_c[MAX_BLOCKS].found) begin
				status_q <= ST_ALLOCATED;
				ridx_q   <= idx_c[MAX_BLOCKS];
				rused_q  <= used_c[MAX_BLOCKS] + size_q;
				rfree_q  <= free_c[MAX_BLOCKS] - size_q;
			end else begin
				status_q <= ST_NOT_ALLOCATED;
				ridx_q   <= '0;
				rused_q  <= '0;
				rfree_q  <= '0;
			end
		end
	end

	assign idx_ext  = {4'b0, ridx_q};
	assign used_ext = {16'b0, rused_q};
	assign free_ext = {16'b0, rfree_q};

	assign busy        = busy_q;
	assign done        = done_q;
	assign status      = status_q;
	assign block_index = idx_ext[3:0];
	assign used_after  = used_ext[15:0];
	assign free_after  = free_ext[15:0];

endmodule

// File: rtl/core/wfba_checker.sv
// ----------------------------------------------------------------------------
// wfba_checker
// Port-level checks on request and result sequencing, bound to the top level.
// ----------------------------------------------------------------------------
module wfba_checker
	import wfba_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       req_type,
	input logic       done,
	input logic [1:0] status
);

	// an accepted allocate holds busy on the next cycle
	a_alloc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req_type == REQ_ALLOC) |=> busy)
		else $error("allocate accepted without busy");

	// a load word answers in the next cycle with a load status
	a_load_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req_type == REQ_LOAD) |=>
			(done && (status == ST_LOADED || status == ST_FULL)))
		else $error("load result missing or wrong kind");

	// end of an allocate delivers an allocate status
	a_alloc_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (done && (status == ST_ALLOCATED || status == ST_NOT_ALLOCATED)))
		else $error("allocate finished without result");

	// no result while a scan is still running
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result during scan");

endmodule

bind worst_fit_block_allocator_unit wfba_checker u_wfba_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.req_type(req_type),
	.done    (done),
	.status  (status)
);
